// ----- hw/rtl/bpme_pkg.sv -----
package bpme_pkg;

    localparam logic [1:0] ACT_PLANE = 2'd0;
    localparam logic [1:0] ACT_EMPTY = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_BOUNDS  = 2'd1;
    localparam logic [1:0] ST_EMPTY_BRUSH = 2'd2;
    localparam logic [1:0] ST_BAD_PLANE   = 2'd3;

    localparam int CFG_COUNT = 6;

    // iteration counts of the serial divider, one quotient bit per cycle
    localparam logic [6:0] DIV_BITS_UNIT = 7'd62;
    localparam logic [6:0] DIV_BITS_DIST = 7'd48;

    typedef struct packed {
        logic        start;
        logic [6:0]  count;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } bpme_div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } bpme_div_rsp_t;

endpackage

// ----- hw/rtl/brush_plane_minkowski_expand_core.sv -----
// channel | dir | handshake                  | payload
// s_axis  | in  | s_axis_tvalid/tready       | tdata normals+offset, tuser action, tlast
// m_axis  | out | m_axis_tvalid/tready       | tdata units+offset+numbers, tuser status,
//         |     |                            | tlast brush_done
// cfg     | in  | cfg_valid/cfg_ready        | cfg_index, cfg_data
// A plane goes from its accept through decode, the sum of squares, the bit-serial root,
// the shared one-bit-per-cycle divider (three unit components, then the offset), the
// corner dot product, rounding and delivery, and back to idle. A zero normal skips the
// root and the divider; start and empty-brush requests end at the decode step.
// The divider dominates the time per plane. Reset clears counters, error flag and cfg registers.
// One request is in flight; a pending result stalls the final step and the start, empty-brush and zero-normal steps.
module brush_plane_minkowski_expand_core
#(
    parameter int MAX_BRUSHES          = 65536,
    parameter int MAX_PLANES_PER_BRUSH = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // normal_x [31:0], normal_y [63:32], normal_z [95:64], plane_offset [127:96]
    input  logic [127:0] s_axis_tdata,
    // action [1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // unit_x [31:0], unit_y [63:32], unit_z [95:64], expanded_offset [127:96],
    // brush_number [143:128], plane_number [151:144]
    output logic [151:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int BW  = (MAX_BRUSHES > 1) ? $clog2(MAX_BRUSHES) : 1;
    localparam int PW  = (MAX_PLANES_PER_BRUSH > 1) ? $clog2(MAX_PLANES_PER_BRUSH) : 1;
    localparam int BWX = (BW > 16) ? BW : 16;
    localparam int PWX = (PW > 8) ? PW : 8;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_SQ_MUL  = 4'd2;
    localparam logic [3:0] S_SQ_ACC  = 4'd3;
    localparam logic [3:0] S_RT_GO   = 4'd4;
    localparam logic [3:0] S_RT_WAIT = 4'd5;
    localparam logic [3:0] S_DV_GO   = 4'd6;
    localparam logic [3:0] S_DV_WAIT = 4'd7;
    localparam logic [3:0] S_CN_MUL  = 4'd8;
    localparam logic [3:0] S_CN_ACC  = 4'd9;
    localparam logic [3:0] S_ROUND   = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;
    localparam logic [3:0] S_ZERO    = 4'd12;

    logic [3:0] state_reg, state_next;

    localparam int CFG_COUNT_L = bpme_pkg::CFG_COUNT;
    logic [31:0] cfg_reg [CFG_COUNT_L];

    logic [1:0]        act_reg;
    logic [31:0]       n_reg [3];
    logic [31:0]       off_reg;
    logic              last_reg;

    logic [BW-1:0]     brush_cnt_reg, brush_cnt_next;
    logic [PW-1:0]     plane_cnt_reg, plane_cnt_next;
    logic              failed_reg, failed_next;
    logic [1:0]        idx_reg, idx_next;

    logic signed [63:0] prod_reg;
    logic [63:0]        acc_reg, acc_next;
    logic [31:0]        root_reg, root_next;
    logic [31:0]        u_reg [3];
    logic signed [48:0] dist_reg;
    logic signed [35:0] corner_reg;

    logic               out_valid_reg, out_valid_next;
    logic [151:0]       out_data_reg, out_data_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               in_accept;

    logic signed [31:0] mul_a, mul_b;

    logic               rt_start, rt_done;
    logic [31:0]        rt_root;
    bpme_pkg::bpme_div_req_t div_req;
    bpme_pkg::bpme_div_rsp_t div_rsp;

    logic [31:0]        sel_n;
    logic [31:0]        mag;
    logic [63:0]        mag_unit, mag_dist;
    logic               bad_bounds;
    logic               u_neg;
    logic [31:0]        corner_cfg;

    logic [63:0]        cmag;
    logic [33:0]        cq;
    logic signed [49:0] total;
    logic [31:0]        total_sat;

    logic [BWX-1:0]     brush_ext;
    logic [PWX-1:0]     plane_ext;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign sel_n = (idx_reg == 2'd3) ? off_reg : n_reg[idx_reg];
    assign mag   = sel_n[31] ? 32'(~sel_n + 32'd1) : sel_n;
    // dividends are aligned so the top quotient bit lands in the first step
    assign mag_unit = (({32'd0, mag} << 30) + {33'd0, root_reg[31:1]}) << 2;
    assign mag_dist = (({32'd0, mag} << 16) + {33'd0, root_reg[31:1]}) << 16;

    assign bad_bounds =
        ($signed(cfg_reg[0]) > $signed(cfg_reg[3])) ||
        ($signed(cfg_reg[1]) > $signed(cfg_reg[4])) ||
        ($signed(cfg_reg[2]) > $signed(cfg_reg[5]));

    assign u_neg      = u_reg[idx_reg][31];
    assign corner_cfg = u_neg ? cfg_reg[3'(idx_reg) + 3'd3] : cfg_reg[3'(idx_reg)];

    always_comb
    begin
        if (state_reg == S_CN_MUL)
        begin
            mul_a = $signed(u_reg[idx_reg]);
            mul_b = $signed(corner_cfg);
        end
        else
        begin
            mul_a = $signed(n_reg[idx_reg]);
            mul_b = $signed(n_reg[idx_reg]);
        end
    end

    assign cmag  = acc_reg[63] ? 64'(~acc_reg + 64'd1) : acc_reg;
    assign cq    = 34'((cmag + 64'd536870912) >> 30);
    assign total = 50'(dist_reg) + 50'(corner_reg);
    always_comb
    begin
        if (total > 50'sd2147483647)
            total_sat = 32'h7FFFFFFF;
        else if (total < -50'sd2147483648)
            total_sat = 32'h80000000;
        else
            total_sat = total[31:0];
    end

    assign brush_ext = BWX'(brush_cnt_reg);
    assign plane_ext = PWX'(plane_cnt_reg);

    assign div_req.count    = (idx_reg == 2'd3) ? bpme_pkg::DIV_BITS_DIST
                                                : bpme_pkg::DIV_BITS_UNIT;
    assign div_req.dividend = (idx_reg == 2'd3) ? mag_dist : mag_unit;
    assign div_req.divisor  = root_reg;
    assign div_req.start    = (state_reg == S_DV_GO);
    assign rt_start         = (state_reg == S_RT_GO);

    bpme_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_start),
        .value (acc_reg),
        .done  (rt_done),
        .root  (rt_root)
    );

    bpme_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        brush_cnt_next  = brush_cnt_reg;
        plane_cnt_next  = plane_cnt_reg;
        failed_next     = failed_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        root_next       = root_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                unique case (act_reg)
                    bpme_pkg::ACT_START:
                    begin
                        if (out_free)
                        begin
                            brush_cnt_next = '0;
                            plane_cnt_next = '0;
                            failed_next    = bad_bounds;
                            if (bad_bounds)
                            begin
                                out_valid_next  = 1'b1;
                                out_data_next   = '0;
                                out_status_next = bpme_pkg::ST_BAD_BOUNDS;
                                out_last_next   = 1'b0;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    bpme_pkg::ACT_EMPTY:
                    begin
                        if (failed_reg)
                            state_next = S_IDLE;
                        else if (out_free)
                        begin
                            failed_next     = 1'b1;
                            out_valid_next  = 1'b1;
                            out_data_next   = {8'd0, brush_ext[15:0], 128'd0};
                            out_status_next = bpme_pkg::ST_EMPTY_BRUSH;
                            out_last_next   = 1'b0;
                            state_next      = S_IDLE;
                        end
                    end
                    bpme_pkg::ACT_PLANE:
                    begin
                        if (failed_reg)
                            state_next = S_IDLE;
                        else
                        begin
                            idx_next   = 2'd0;
                            acc_next   = '0;
                            state_next = S_SQ_MUL;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SQ_MUL:
                state_next = S_SQ_ACC;
            S_SQ_ACC:
            begin
                acc_next = acc_reg + 64'(prod_reg);
                if (idx_reg == 2'd2)
                    state_next = S_RT_GO;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_RT_GO:
                state_next = (acc_reg == 64'd0) ? S_ZERO : S_RT_WAIT;
            S_RT_WAIT:
            begin
                if (rt_done)
                begin
                    root_next  = rt_root;
                    idx_next   = 2'd0;
                    state_next = S_DV_GO;
                end
            end
            S_DV_GO:
                state_next = S_DV_WAIT;
            S_DV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = 2'd0;
                        acc_next   = '0;
                        state_next = S_CN_MUL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_DV_GO;
                    end
                end
            end
            S_CN_MUL:
                state_next = S_CN_ACC;
            S_CN_ACC:
            begin
                // accumulate the dot product with the negated corner
                acc_next = acc_reg - 64'(prod_reg);
                if (idx_reg == 2'd2)
                    state_next = S_ROUND;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_CN_MUL;
                end
            end
            S_ROUND:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = {plane_ext[7:0], brush_ext[15:0], total_sat,
                                       u_reg[2], u_reg[1], u_reg[0]};
                    out_status_next = bpme_pkg::ST_OK;
                    out_last_next   = last_reg;
                    if (last_reg)
                    begin
                        plane_cnt_next = '0;
                        brush_cnt_next = (32'(brush_cnt_reg) == 32'(MAX_BRUSHES - 1))
                                         ? '0 : BW'(brush_cnt_reg + 1'b1);
                    end
                    else
                        plane_cnt_next = (32'(plane_cnt_reg) == 32'(MAX_PLANES_PER_BRUSH - 1))
                                         ? '0 : PW'(plane_cnt_reg + 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    failed_next     = 1'b1;
                    out_valid_next  = 1'b1;
                    out_data_next   = {plane_ext[7:0], brush_ext[15:0], 128'd0};
                    out_status_next = bpme_pkg::ST_BAD_PLANE;
                    out_last_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            brush_cnt_reg <= '0;
            plane_cnt_reg <= '0;
            failed_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CFG_COUNT_L; i++)
                cfg_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            brush_cnt_reg <= brush_cnt_next;
            plane_cnt_reg <= plane_cnt_next;
            failed_reg    <= failed_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready && (32'(cfg_index) < 32'(CFG_COUNT_L)))
                cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= s_axis_tuser;
            n_reg[0] <= s_axis_tdata[31:0];
            n_reg[1] <= s_axis_tdata[63:32];
            n_reg[2] <= s_axis_tdata[95:64];
            off_reg  <= s_axis_tdata[127:96];
            last_reg <= s_axis_tlast;
        end
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        if (state_reg == S_DV_WAIT && div_rsp.done)
        begin
            // a zero quotient keeps the sign clear so the minimum corner is taken
            if (idx_reg == 2'd3)
                dist_reg <= sel_n[31] ? -$signed({1'b0, div_rsp.quotient})
                                      : $signed({1'b0, div_rsp.quotient});
            else
                u_reg[idx_reg] <= sel_n[31] ? 32'(~div_rsp.quotient + 48'd1)
                                            : div_rsp.quotient[31:0];
        end
        if (state_reg == S_ROUND)
            corner_reg <= acc_reg[63] ? -$signed({2'b00, cq}) : $signed({2'b00, cq});
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/bpme_isqrt.sv -----
module bpme_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] val_reg, val_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [35:0] rem_sh;
    logic [35:0] trial;

    assign rem_sh = {rem_reg, val_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // two radicand bits in, one root bit out
            val_next = {val_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = 34'(rem_sh - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- hw/rtl/bpme_div.sv -----
module bpme_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bpme_pkg::bpme_div_req_t req,
    output bpme_pkg::bpme_div_rsp_t rsp
);

    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [31:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = req.count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            rem_next = ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
            quo_next = {quo_reg[46:0], ge};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- verif/tb_brush_plane_minkowski_expand_core.sv -----
module tb_brush_plane_minkowski_expand_core;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int         IDLE_SETTLE = 400;
    localparam int         STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [31:0] offset;
        logic        last;
    } plane_req_t;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [31:0] eoff;
        logic [15:0] brush;
        logic [7:0]  plane;
        logic [1:0]  status;
        logic        done;
    } expanded_plane_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    brush_plane_minkowski_expand_core dut (.*);

    // predictor state
    logic signed [31:0] agent_box [bpme_pkg::CFG_COUNT];
    logic [15:0]        cur_brush;
    logic [7:0]         cur_plane;
    logic               job_dead;

    plane_req_t      pending_reqs [$];
    expanded_plane_t expected_planes [$];
    int              errors;
    int              quiet_cycles;
    int              recv_wait;
    int              send_wait;
    int              hold_cycles;
    bit              hold_req;
    logic            in_taken;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] round_div(input logic signed [63:0] num,
                                                     input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        mag = num < 0 ? 64'(-num) : 64'(num);
        q   = (mag + den / 2) / den;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic bit expand_plane(input plane_req_t rq, output expanded_plane_t ex);
        logic signed [63:0] n [3];
        logic signed [63:0] u [3];
        logic signed [63:0] c;
        logic signed [63:0] corner;
        logic signed [63:0] total;
        logic [63:0]        s;
        logic [63:0]        r;
        ex = '0;
        if (rq.action == bpme_pkg::ACT_START)
        begin
            cur_brush = 0;
            cur_plane = 0;
            job_dead  = 1'b0;
            for (int a = 0; a < 3; a++)
                if (agent_box[a] > agent_box[a + 3])
                begin
                    job_dead  = 1'b1;
                    ex.status = bpme_pkg::ST_BAD_BOUNDS;
                    return 1;
                end
            return 0;
        end
        if (rq.action == ACT_IGNORED || job_dead) return 0;
        ex.brush = cur_brush;
        if (rq.action == bpme_pkg::ACT_EMPTY)
        begin
            job_dead  = 1'b1;
            ex.status = bpme_pkg::ST_EMPTY_BRUSH;
            return 1;
        end
        n[0] = $signed(rq.nx);
        n[1] = $signed(rq.ny);
        n[2] = $signed(rq.nz);
        s = 0;
        for (int a = 0; a < 3; a++) s = s + 64'(n[a] * n[a]);
        ex.plane = cur_plane;
        if (s == 0)
        begin
            job_dead  = 1'b1;
            ex.status = bpme_pkg::ST_BAD_PLANE;
            return 1;
        end
        r = isqrt(s);
        corner = 0;
        for (int a = 0; a < 3; a++)
        begin
            u[a]   = round_div(n[a] <<< 30, r);
            c      = u[a] >= 0 ? 64'(agent_box[a]) : 64'(agent_box[a + 3]);
            corner = corner + u[a] * (-c);
        end
        corner = round_div(corner, 64'd1 << 30);
        total  = round_div(64'($signed(rq.offset)) <<< 16, r) + corner;
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        ex.ux     = u[0][31:0];
        ex.uy     = u[1][31:0];
        ex.uz     = u[2][31:0];
        ex.eoff   = total[31:0];
        ex.status = bpme_pkg::ST_OK;
        ex.done   = rq.last;
        if (rq.last)
        begin
            cur_plane = 0;
            cur_brush = cur_brush + 1;
        end
        else
            cur_plane = cur_plane + 1;
        return 1;
    endfunction

    // mark the requests taken at the rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // driver: prediction happens at acceptance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                expanded_plane_t ex;
                if (expand_plane(pending_reqs.pop_front(), ex))
                    expected_planes.insert(expected_planes.size(), ex);
                send_wait = $urandom_range(0, 9);
            end
            if (s_axis_tvalid && !in_taken)
                ;
            else if (send_wait > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait--;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].action;
                s_axis_tdata  <= {pending_reqs[0].offset, pending_reqs[0].nz,
                                  pending_reqs[0].ny, pending_reqs[0].nx};
                s_axis_tlast  <= pending_reqs[0].last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // sink side ready pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req    <= 1'b0;
                hold_cycles  = 3000;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                expanded_plane_t got;
                expanded_plane_t want;
                recv_wait = $urandom_range(0, 9);
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tdata[127:96], m_axis_tdata[143:128], m_axis_tdata[151:144],
                       m_axis_tuser, m_axis_tlast};
                if (expected_planes.size() == 0)
                begin
                    $display("%0t unexpected result exp none got %h", $realtime, got);
                    errors++;
                end
                else
                begin
                    want = expected_planes.pop_front();
                    if (got.ux !== want.ux)
                    begin
                        $display("%0t unit_x exp %h got %h", $realtime, want.ux, got.ux);
                        errors++;
                    end
                    if (got.uy !== want.uy)
                    begin
                        $display("%0t unit_y exp %h got %h", $realtime, want.uy, got.uy);
                        errors++;
                    end
                    if (got.uz !== want.uz)
                    begin
                        $display("%0t unit_z exp %h got %h", $realtime, want.uz, got.uz);
                        errors++;
                    end
                    if (got.eoff !== want.eoff)
                    begin
                        $display("%0t offset exp %h got %h", $realtime, want.eoff, got.eoff);
                        errors++;
                    end
                    if (got.brush !== want.brush)
                    begin
                        $display("%0t brush exp %h got %h", $realtime, want.brush, got.brush);
                        errors++;
                    end
                    if (got.plane !== want.plane)
                    begin
                        $display("%0t plane exp %h got %h", $realtime, want.plane, got.plane);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t status exp %h got %h", $realtime, want.status, got.status);
                        errors++;
                    end
                    if (got.done !== want.done)
                    begin
                        $display("%0t done exp %h got %h", $realtime, want.done, got.done);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input int idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= 3'(idx);
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        agent_box[idx] = $signed(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_planes.size() > 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic set_box(input logic [31:0] mnx, mny, mnz, mxx, mxy, mxz);
        write_reg(0, mnx);
        write_reg(1, mny);
        write_reg(2, mnz);
        write_reg(3, mxx);
        write_reg(4, mxy);
        write_reg(5, mxz);
    endtask

    function automatic plane_req_t mk(input logic [1:0] act, input logic [31:0] x, y, z, d,
                                      input logic l);
        plane_req_t rq;
        rq = {act, x, y, z, d, l};
        return rq;
    endfunction

    task automatic queue_req(input plane_req_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_bound();
        return $urandom_range(0, 3) == 0 ? $urandom
                                         : 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endfunction

    // a job: start, a few brushes, mostly well formed
    task automatic queue_job();
        int nb;
        int np;
        queue_req(mk(bpme_pkg::ACT_START, $urandom, $urandom, $urandom, $urandom,
                     1'($urandom)));
        nb = $urandom_range(1, 5);
        for (int b = 0; b < nb; b++)
        begin
            np = $urandom_range(1, 8);
            for (int p = 0; p < np; p++)
            begin
                logic [1:0] act;
                act = bpme_pkg::ACT_PLANE;
                case ($urandom_range(0, 60))
                    0: act = bpme_pkg::ACT_EMPTY;
                    1: act = ACT_IGNORED;
                    default: act = bpme_pkg::ACT_PLANE;
                endcase
                queue_req(mk(act, rand_comp(), rand_comp(),
                    $urandom_range(0, 50) == 0 ? 32'd0 : rand_comp(),
                    rand_comp(), p == np - 1));
            end
        end
    endtask

    initial
    begin
        errors        = 0;
        quiet_cycles  = 0;
        recv_wait     = 0;
        send_wait     = 0;
        hold_cycles   = 0;
        hold_req      = 1'b0;
        cur_brush     = 0;
        cur_plane     = 0;
        job_dead      = 1'b0;
        for (int i = 0; i < bpme_pkg::CFG_COUNT; i++) agent_box[i] = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: typical box, extremes, every action, empty-brush and zero-normal errors
        set_box(32'hffF0_0000, 32'hffF0_0000, 32'hffE0_0000,
                32'h0010_0000, 32'h0010_0000, 32'h0048_0000);
        queue_req(mk(bpme_pkg::ACT_START, 0, 0, 0, 0, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'h0001_0000, 0, 0, 32'h0040_0000, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'hffff_0000, 0, 0, 32'hffc0_0000, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 1, 0, 0, 32'h7fff_ffff, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 0, 0, 32'hffff_ffff, 32'h8000_0000, 0));
        queue_req(mk(ACT_IGNORED, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, 32'hffff_ffff, 1));
        queue_req(mk(bpme_pkg::ACT_PLANE, 0, 32'h0003_0000, 32'h0004_0000, 5, 1));
        queue_req(mk(bpme_pkg::ACT_EMPTY, 0, 0, 0, 0, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 1, 1, 1, 1, 1));
        queue_req(mk(bpme_pkg::ACT_START, 0, 0, 0, 0, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'h0002_0000, 0, 0, 0, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 0, 0, 0, 32'h1234_5678, 0));
        queue_req(mk(bpme_pkg::ACT_EMPTY, 0, 0, 0, 0, 1));
        wait_drained();

        // inverted bounds on each axis, then extreme registers
        for (int a = 0; a < 3; a++)
        begin
            write_reg(a, 32'h0000_0001);
            write_reg(a + 3, 32'h0000_0000);
            queue_req(mk(bpme_pkg::ACT_START, 0, 0, 0, 0, 0));
            queue_req(mk(bpme_pkg::ACT_PLANE, 32'h0001_0000, 0, 0, 0, 1));
            wait_drained();
            write_reg(a, 32'h0000_0000);
        end
        set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_req(mk(bpme_pkg::ACT_START, 0, 0, 0, 0, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000,
                     32'h7fff_ffff, 0));
        queue_req(mk(bpme_pkg::ACT_PLANE, 32'hffff_0000, 32'h0001_0000, 32'hffff_0000,
                     32'h8000_0000, 1));
        wait_drained();

        // one brush long enough to wrap the plane number
        queue_req(mk(bpme_pkg::ACT_START, 0, 0, 0, 0, 0));
        for (int p = 0; p < 260; p++)
            queue_req(mk(bpme_pkg::ACT_PLANE, rand_comp() | 32'd1, rand_comp(), rand_comp(),
                         rand_comp(), p == 259));
        wait_drained();

        // random jobs under several box settings; long hold-off in one phase
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 2)
                set_box(0, 0, 0, 0, 0, 0);
            else if (phase == 5)
                set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
            else
            begin
                logic [31:0] lo;
                logic [31:0] hi;
                for (int a = 0; a < 3; a++)
                begin
                    lo = rand_bound();
                    hi = rand_bound();
                    if ($urandom_range(0, 7) != 0 && $signed(lo) > $signed(hi))
                        {lo, hi} = {hi, lo};
                    write_reg(a, lo);
                    write_reg(a + 3, hi);
                end
            end
            while (pending_reqs.size() < 25) queue_job();
            if (phase == 3) hold_req = 1'b1;
            wait_drained();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- brush_plane_minkowski_expand_core.f -----
hw/rtl/bpme_pkg.sv
hw/rtl/bpme_isqrt.sv
hw/rtl/bpme_div.sv
hw/rtl/brush_plane_minkowski_expand_core.sv
verif/tb_brush_plane_minkowski_expand_core.sv
